@@ sv/sssp_pkg.sv @@
// ----------------------------------------------------------------------------
// sssp_pkg
// Shared constants, codes and state type of the shortest-path unit.
// ----------------------------------------------------------------------------
package sssp_pkg;

    localparam int MAX_NODES_DEF   = 4096;
    localparam int MAX_EDGES_DEF   = 8192;
    localparam int WEIGHT_BITS_DEF = 16;

    localparam int NODE_BITS = 12;
    localparam int LEN_BITS  = 16;
    localparam int DIST_BITS = 28;
    localparam int IN_DATA_BITS  = 40;
    localparam int OUT_DATA_BITS = 32;

    localparam logic [DIST_BITS-1:0] DIST_MAX = 28'h0FFFFFFF;

    localparam logic FUNC_ADD   = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    localparam logic STATUS_OK   = 1'b0;
    localparam logic STATUS_FULL = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD_RDA,
        ST_ADD_WRA,
        ST_ADD_RDB,
        ST_ADD_WRB,
        ST_Q_CLR,
        ST_Q_SRC,
        ST_Q_SCAN,
        ST_Q_PICK,
        ST_Q_HEAD,
        ST_Q_ERD,
        ST_Q_EDAT,
        ST_Q_NDAT,
        ST_Q_TRD,
        ST_Q_TDAT
    } t_state;

endpackage

@@ sv/sssp_ram.sv @@
// ----------------------------------------------------------------------------
// sssp_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module sssp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ sv/single_source_shortest_path_unit.sv @@
// ----------------------------------------------------------------------------
// single_source_shortest_path_unit
// Stores an undirected weighted graph as adjacency lists and answers
// shortest-path queries by scan-based Dijkstra relaxation.
// ----------------------------------------------------------------------------
// channel  dir  handshake            payload
// s        in   i_s_tvalid/o_s_tready tuser: func; tdata: node_a, node_b, edge_length
// m        out  o_m_tvalid/i_m_tready tdata: status, reachable, path_length
//
// An add makes two head-RAM read/write rounds; a dropped or out-of-range item
// is answered straight from the idle state. A query clears every node RAM entry
// and seeds the source, then for each settled node scans the node RAM and
// picks, fetches the list head and walks its list entry by entry; a final scan
// and pick and a read of the target node's entry finish. The node RAM has a
// single read port, so the scan reads it one entry at a time.
// Reset clears control state and the edge count; list heads start empty by a
// head-RAM clearing pass over all MAX_NODES entries after reset, no item accepted.
// A result waits in the output register; a new item is taken once it drains.
// ----------------------------------------------------------------------------
module single_source_shortest_path_unit #(
    parameter int MAX_NODES   = sssp_pkg::MAX_NODES_DEF,
    parameter int MAX_EDGES   = sssp_pkg::MAX_EDGES_DEF,
    parameter int WEIGHT_BITS = sssp_pkg::WEIGHT_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // [11:0] node_a, [23:12] node_b, [39:24] edge_length
    input  logic [sssp_pkg::IN_DATA_BITS-1:0]  i_s_tdata,
    // [0] func
    input  logic                               i_s_tuser,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [0] status, [1] reachable, [29:2] path_length, [31:30] zero
    output logic [sssp_pkg::OUT_DATA_BITS-1:0] o_m_tdata
);

    localparam int NW    = $clog2(MAX_NODES);
    localparam int SLOTS = 2 * MAX_EDGES + 1;
    localparam int EW    = $clog2(SLOTS);
    localparam int DB    = sssp_pkg::DIST_BITS;
    localparam int NB    = sssp_pkg::NODE_BITS;
    localparam int NDW   = DB + 2;
    localparam int EDW   = NB + WEIGHT_BITS + EW;

    sssp_pkg::t_state r_state, n_state;

    logic [NB-1:0]          r_a, n_a, r_b, n_b;
    logic [WEIGHT_BITS-1:0] r_w, n_w;
    logic [EW-1:0]          r_total, n_total;
    logic [NW:0]            r_idx, n_idx;
    logic                   r_pend, n_pend;
    logic [NW-1:0]          r_pidx, n_pidx;
    logic                   r_found, n_found;
    logic [NW-1:0]          r_best, n_best;
    logic [DB-1:0]          r_bestd, n_bestd;
    logic [EW-1:0]          r_edge, n_edge;
    logic [NB-1:0]          r_v, n_v;
    logic [DB-1:0]          r_cand, n_cand;
    logic                   r_init, n_init;
    logic                   r_out_valid, n_out_valid;
    logic                   r_out_status, n_out_status;
    logic                   r_out_reach, n_out_reach;
    logic [DB-1:0]          r_out_len, n_out_len;

    // memory ports
    logic           head_we;
    logic [NW-1:0]  head_waddr, head_raddr;
    logic [EW-1:0]  head_wdata, head_rdata;
    logic           edge_we;
    logic [EW-1:0]  edge_waddr, edge_raddr;
    logic [EDW-1:0] edge_wdata, edge_rdata;
    logic           node_we;
    logic [NW-1:0]  node_waddr, node_raddr;
    logic [NDW-1:0] node_wdata, node_rdata;

    logic                   s_acc;
    logic                   in_func;
    logic [NB-1:0]          in_a, in_b;
    logic [sssp_pkg::LEN_BITS-1:0] in_len;
    logic                   in_range;
    logic                   store_full;
    logic [31:0]            a_ext, b_ext, best_ext, v_ext, pidx_ext;
    logic [NW-1:0]          a_addr, b_addr, v_addr, idx_addr;
    logic [DB-1:0]          nd_dist;
    logic                   nd_vis, nd_reach;
    logic [NB-1:0]          ed_dest;
    logic [WEIGHT_BITS-1:0] ed_w;
    logic [EW-1:0]          ed_link;
    logic [DB+WEIGHT_BITS:0] sum;
    logic [DB-1:0]          sum_sat;
    logic                   scan_last, clr_last, idx_end;

    assign in_func = i_s_tuser;
    assign in_a    = i_s_tdata[NB-1:0];
    assign in_b    = i_s_tdata[2*NB-1:NB];
    assign in_len  = i_s_tdata[2*NB +: sssp_pkg::LEN_BITS];
    assign in_range = (32'(in_a) < MAX_NODES) && (32'(in_b) < MAX_NODES);
    assign store_full = ({1'b0, r_total} + (EW+1)'(2)) > (EW+1)'(2 * MAX_EDGES);

    assign a_ext    = 32'(r_a);
    assign b_ext    = 32'(r_b);
    assign v_ext    = 32'(r_v);
    assign a_addr   = a_ext[NW-1:0];
    assign b_addr   = b_ext[NW-1:0];
    assign v_addr   = v_ext[NW-1:0];
    assign idx_addr = r_idx[NW-1:0];
    assign best_ext = 32'(r_best);
    assign pidx_ext = 32'(r_pidx);

    assign nd_dist  = node_rdata[NDW-1:2];
    assign nd_vis   = node_rdata[1];
    assign nd_reach = node_rdata[0];
    assign ed_dest  = edge_rdata[EDW-1 -: NB];
    assign ed_w     = edge_rdata[EW +: WEIGHT_BITS];
    assign ed_link  = edge_rdata[EW-1:0];

    assign sum     = (DB+WEIGHT_BITS+1)'(r_bestd) + (DB+WEIGHT_BITS+1)'(ed_w);
    assign sum_sat = (sum > (DB+WEIGHT_BITS+1)'(sssp_pkg::DIST_MAX))
                     ? sssp_pkg::DIST_MAX : sum[DB-1:0];

    assign idx_end   = (r_idx == (NW+1)'(MAX_NODES));
    assign clr_last  = (r_idx == (NW+1)'(MAX_NODES - 1));
    assign scan_last = idx_end && !r_pend;

    assign o_s_tready = (r_state == sssp_pkg::ST_IDLE) && !r_init
                        && (!r_out_valid || i_m_tready);
    assign s_acc      = i_s_tvalid && o_s_tready;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sssp_pkg::ST_IDLE: begin
                if (s_acc && in_range) begin
                    if (in_func == sssp_pkg::FUNC_QUERY) begin
                        n_state = sssp_pkg::ST_Q_CLR;
                    end else if (!store_full) begin
                        n_state = sssp_pkg::ST_ADD_RDA;
                    end
                end
            end
            sssp_pkg::ST_ADD_RDA: n_state = sssp_pkg::ST_ADD_WRA;
            sssp_pkg::ST_ADD_WRA: n_state = sssp_pkg::ST_ADD_RDB;
            sssp_pkg::ST_ADD_RDB: n_state = sssp_pkg::ST_ADD_WRB;
            sssp_pkg::ST_ADD_WRB: n_state = sssp_pkg::ST_IDLE;
            sssp_pkg::ST_Q_CLR: begin
                if (clr_last) begin
                    n_state = sssp_pkg::ST_Q_SRC;
                end
            end
            sssp_pkg::ST_Q_SRC: n_state = sssp_pkg::ST_Q_SCAN;
            sssp_pkg::ST_Q_SCAN: begin
                if (scan_last) begin
                    n_state = sssp_pkg::ST_Q_PICK;
                end
            end
            sssp_pkg::ST_Q_PICK: begin
                n_state = r_found ? sssp_pkg::ST_Q_HEAD : sssp_pkg::ST_Q_TRD;
            end
            sssp_pkg::ST_Q_HEAD: begin
                n_state = (head_rdata == '0) ? sssp_pkg::ST_Q_SCAN : sssp_pkg::ST_Q_ERD;
            end
            sssp_pkg::ST_Q_ERD:  n_state = sssp_pkg::ST_Q_EDAT;
            sssp_pkg::ST_Q_EDAT: n_state = sssp_pkg::ST_Q_NDAT;
            sssp_pkg::ST_Q_NDAT: begin
                n_state = (r_edge == '0) ? sssp_pkg::ST_Q_SCAN : sssp_pkg::ST_Q_ERD;
            end
            sssp_pkg::ST_Q_TRD:  n_state = sssp_pkg::ST_Q_TDAT;
            sssp_pkg::ST_Q_TDAT: n_state = sssp_pkg::ST_IDLE;
            default:             n_state = sssp_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory strobes
    always_comb begin
        n_a = r_a;
        n_b = r_b;
        n_w = r_w;
        n_total = r_total;
        n_idx = r_idx;
        n_pend = 1'b0;
        n_pidx = r_idx[NW-1:0];
        n_found = r_found;
        n_best = r_best;
        n_bestd = r_bestd;
        n_edge = r_edge;
        n_v = r_v;
        n_cand = r_cand;
        n_init = r_init;
        n_out_valid = r_out_valid && !i_m_tready;
        n_out_status = r_out_status;
        n_out_reach = r_out_reach;
        n_out_len = r_out_len;

        head_we = 1'b0;
        head_waddr = a_addr;
        head_wdata = r_total + EW'(1);
        head_raddr = a_addr;
        edge_we = 1'b0;
        edge_waddr = r_total + EW'(1);
        edge_wdata = {r_b, r_w, head_rdata};
        edge_raddr = r_edge;
        node_we = 1'b0;
        node_waddr = idx_addr;
        node_wdata = '0;
        node_raddr = idx_addr;

        unique case (r_state)
            sssp_pkg::ST_IDLE: begin
                if (r_init) begin
                    // clear list heads after reset
                    head_we = 1'b1;
                    head_waddr = idx_addr;
                    head_wdata = '0;
                    n_idx = r_idx + (NW+1)'(1);
                    if (clr_last) begin
                        n_init = 1'b0;
                        n_idx = '0;
                    end
                end else if (s_acc) begin
                    n_a = in_a;
                    n_b = in_b;
                    n_w = WEIGHT_BITS'(in_len);
                    n_idx = '0;
                    if (!in_range || (in_func == sssp_pkg::FUNC_ADD && store_full)) begin
                        n_out_valid = 1'b1;
                        n_out_status = (in_func == sssp_pkg::FUNC_ADD && in_range)
                                       ? sssp_pkg::STATUS_FULL : sssp_pkg::STATUS_OK;
                        n_out_reach = 1'b0;
                        n_out_len = '0;
                    end
                end
            end
            sssp_pkg::ST_ADD_RDA: begin
                head_raddr = a_addr;
            end
            sssp_pkg::ST_ADD_WRA: begin
                edge_we = 1'b1;
                edge_wdata = {r_b, r_w, head_rdata};
                head_we = 1'b1;
                head_waddr = a_addr;
                n_total = r_total + EW'(1);
            end
            sssp_pkg::ST_ADD_RDB: begin
                head_raddr = b_addr;
            end
            sssp_pkg::ST_ADD_WRB: begin
                edge_we = 1'b1;
                edge_wdata = {r_a, r_w, head_rdata};
                head_we = 1'b1;
                head_waddr = b_addr;
                n_total = r_total + EW'(1);
                n_out_valid = 1'b1;
                n_out_status = sssp_pkg::STATUS_OK;
                n_out_reach = 1'b0;
                n_out_len = '0;
            end
            sssp_pkg::ST_Q_CLR: begin
                node_we = 1'b1;
                node_waddr = idx_addr;
                node_wdata = '0;
                n_idx = r_idx + (NW+1)'(1);
            end
            sssp_pkg::ST_Q_SRC: begin
                node_we = 1'b1;
                node_waddr = a_addr;
                node_wdata = {DB'(0), 1'b0, 1'b1};
                n_idx = '0;
                n_found = 1'b0;
            end
            sssp_pkg::ST_Q_SCAN: begin
                node_raddr = idx_addr;
                if (!idx_end) begin
                    n_idx = r_idx + (NW+1)'(1);
                    n_pend = 1'b1;
                end
                // evaluate the entry read last cycle
                if (r_pend && nd_reach && !nd_vis && (!r_found || nd_dist < r_bestd)) begin
                    n_found = 1'b1;
                    n_best = pidx_ext[NW-1:0];
                    n_bestd = nd_dist;
                end
            end
            sssp_pkg::ST_Q_PICK: begin
                if (r_found) begin
                    node_we = 1'b1;
                    node_waddr = best_ext[NW-1:0];
                    node_wdata = {r_bestd, 1'b1, 1'b1};
                    head_raddr = best_ext[NW-1:0];
                end else begin
                    node_raddr = b_addr;
                end
            end
            sssp_pkg::ST_Q_HEAD: begin
                n_edge = head_rdata;
                n_idx = '0;
                n_found = 1'b0;
            end
            sssp_pkg::ST_Q_ERD: begin
                edge_raddr = r_edge;
            end
            sssp_pkg::ST_Q_EDAT: begin
                n_v = ed_dest;
                n_cand = sum_sat;
                n_edge = ed_link;
                node_raddr = 32'(ed_dest) < 32'(MAX_NODES) ? NW'(ed_dest) : '0;
            end
            sssp_pkg::ST_Q_NDAT: begin
                // skip a destination outside the node range
                if (v_ext < 32'(MAX_NODES) && (!nd_reach || r_cand < nd_dist)) begin
                    node_we = 1'b1;
                    node_waddr = v_addr;
                    node_wdata = {r_cand, nd_vis, 1'b1};
                end
                n_idx = '0;
                n_found = 1'b0;
            end
            sssp_pkg::ST_Q_TRD: begin
                node_raddr = b_addr;
            end
            sssp_pkg::ST_Q_TDAT: begin
                n_out_valid = 1'b1;
                n_out_status = sssp_pkg::STATUS_OK;
                n_out_reach = nd_reach;
                n_out_len = nd_reach ? nd_dist : '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sssp_pkg::ST_IDLE;
            r_total <= '0;
            r_idx <= '0;
            r_pend <= 1'b0;
            r_found <= 1'b0;
            r_init <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            r_idx <= n_idx;
            r_pend <= n_pend;
            r_found <= n_found;
            r_init <= n_init;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a <= n_a;
        r_b <= n_b;
        r_w <= n_w;
        r_pidx <= n_pidx;
        r_best <= n_best;
        r_bestd <= n_bestd;
        r_edge <= n_edge;
        r_v <= n_v;
        r_cand <= n_cand;
        r_out_status <= n_out_status;
        r_out_reach <= n_out_reach;
        r_out_len <= n_out_len;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {2'b00, r_out_len, r_out_reach, r_out_status};

    sssp_ram #(.WIDTH(EW), .DEPTH(MAX_NODES)) u_head_ram (
        .i_clk   (i_clk),
        .i_we    (head_we),
        .i_waddr (head_waddr),
        .i_wdata (head_wdata),
        .i_raddr (head_raddr),
        .o_rdata (head_rdata)
    );

    sssp_ram #(.WIDTH(EDW), .DEPTH(SLOTS)) u_edge_ram (
        .i_clk   (i_clk),
        .i_we    (edge_we),
        .i_waddr (edge_waddr),
        .i_wdata (edge_wdata),
        .i_raddr (edge_raddr),
        .o_rdata (edge_rdata)
    );

    sssp_ram #(.WIDTH(NDW), .DEPTH(MAX_NODES)) u_node_ram (
        .i_clk   (i_clk),
        .i_we    (node_we),
        .i_waddr (node_waddr),
        .i_wdata (node_wdata),
        .i_raddr (node_raddr),
        .o_rdata (node_rdata)
    );

endmodule
